// ===== hw/rtl/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
`default_nettype none

package skt_pkg;

  // Request codes on the action field
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_REKEY  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Operation broadcast to every cell of the row
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } cell_ctl_t;

  // What a cell shows to its neighbors and to the row controller
  typedef struct packed {
    logic               valid;
    logic               gt;     // holds a key greater than the broadcast key
    logic               match;  // holds a key equal to the broadcast key
    logic signed [31:0] key;
    logic [31:0]        payload;
  } cell_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skt_cell.sv =====
// One slot of the sorted row: holds a key and payload, shifts left or right.
`default_nettype none

module skt_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                clk,
  input  wire skt_pkg::cell_ctl_t  ctl,
  input  wire logic                found,
  input  wire logic [CNT_W-1:0]    count,
  input  wire skt_pkg::cell_view_t left,
  input  wire skt_pkg::cell_view_t right,
  output skt_pkg::cell_view_t      view,
  output logic [31:0]              hit_pay
);
  import skt_pkg::*;

  logic signed [31:0] key;
  logic [31:0]        pay;
  logic               valid;

  // Slots below the record count hold live records
  assign valid = count > CNT_W'(INDEX);

  assign view.valid   = valid;
  assign view.gt      = valid && (key > ctl.key);
  assign view.match   = valid && (key == ctl.key);
  assign view.key     = key;
  assign view.payload = pay;

  // Keys are sorted, so the first match is the one whose left neighbor misses
  assign hit_pay = (view.match && !left.match) ? pay : '0;

  // Insert: greater keys take the left neighbor, the landing slot takes the new record.
  // Delete: every slot from the first match upward takes its right neighbor.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INS: begin
        if (left.gt) begin
          key <= left.key;
          pay <= left.payload;
        end else if (view.gt || !valid) begin
          key <= ctl.key;
          pay <= ctl.payload;
        end
      end
      OP_DEL: begin
        if (found && valid && (key >= ctl.key)) begin
          key <= right.key;
          pay <= right.payload;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table_top.sv =====
// Top level of the sorted key table: request sequencer, result register and cell row.
//
//   channel  direction  handshake             fields
//   in       input      in_valid / in_stall   action, record_key, new_key, payload
//   out      output     out_valid / out_stall status, entry_count
//
// Insert, delete, refused requests and unused codes are handled in one step; a successful
// change of key takes a delete pass and then an insert pass over the cell row.
// The row shifts all slots at once, so the table depth does not change the number of passes.
// Reset clears the record count and the sequencer; slot contents need no clearing.
// A result waits in the output register while out_stall is high; a new item is taken once
// that register is free or is being read in the same cycle, and no key change is placing its record.
`default_nettype none

module sorted_key_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic signed [31:0] record_key,
  input  wire logic signed [31:0] new_key,
  input  wire logic [31:0] payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [6:0]       entry_count
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PLACE = 1'b1;

  logic               state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   res_count, res_count_next;
  logic [1:0]         status_next;
  logic               res_load;
  logic               out_valid_next;
  logic signed [31:0] rk_key;
  logic [31:0]        rk_pay;
  logic               accept, full, empty, found;
  logic [31:0]        kept;
  logic [CNT_W+6:0]   res_ext;

  cell_ctl_t  ctl;
  cell_view_t views [TABLE_DEPTH];
  logic [31:0] hits [TABLE_DEPTH];

  assign in_stall = (state == S_PLACE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = count == CNT_W'(TABLE_DEPTH);
  assign empty    = count == '0;

  // Command broadcast to the row
  always_comb begin
    ctl.op      = OP_NOP;
    ctl.key     = record_key;
    ctl.payload = payload;
    if (state == S_PLACE) begin
      ctl.op      = OP_INS;
      ctl.key     = rk_key;
      ctl.payload = rk_pay;
    end else if (accept) begin
      case (action)
        ACT_INSERT: if (!full) ctl.op = OP_INS;
        ACT_DELETE, ACT_REKEY: if (!empty) ctl.op = OP_DEL;
        default: ctl.op = OP_NOP;
      endcase
    end
  end

  // Cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_view_t left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = views[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = views[i+1];
    end
    skt_cell #(.INDEX(i), .CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .found   (found),
      .count   (count),
      .left    (left_v),
      .right   (right_v),
      .view    (views[i]),
      .hit_pay (hits[i])
    );
  end

  // Match flag and payload of the first matching record
  always_comb begin
    found = 1'b0;
    kept  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found = found | views[i].match;
      kept  = kept | hits[i];
    end
  end

  // Sequencer and result
  always_comb begin
    state_next     = state;
    count_next     = count;
    res_count_next = res_count;
    status_next    = status;
    res_load       = 1'b0;
    if (state == S_PLACE) begin
      state_next  = S_IDLE;
      count_next  = count + 1'b1;
      status_next = ST_DONE;
      res_load    = 1'b1;
    end else if (accept) begin
      res_load    = 1'b1;
      status_next = ST_DONE;
      case (action)
        ACT_INSERT: begin
          if (full) status_next = ST_FULL;
          else count_next = count + 1'b1;
        end
        ACT_DELETE, ACT_REKEY: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else if (!found) begin
            status_next = ST_MISSING;
          end else begin
            count_next = count - 1'b1;
            if (action == ACT_REKEY) begin
              state_next = S_PLACE;
              res_load   = 1'b0;
            end
          end
        end
        default: status_next = ST_DONE;
      endcase
    end
    if (res_load) res_count_next = count_next;
    out_valid_next = res_load || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_count <= res_count_next;
    status    <= status_next;
    if (state == S_IDLE && accept) begin
      rk_key <= new_key;
      rk_pay <= kept;
    end
  end

  assign res_ext     = {7'b0, res_count};
  assign entry_count = res_ext[6:0];

endmodule

`default_nettype wire

// ===== hw/rtl/skt_checker.sv =====
// Port-level checks for the sorted key table, bound to the top level.
`default_nettype none

module skt_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  action,
  input wire logic [31:0] record_key,
  input wire logic [31:0] new_key,
  input wire logic [31:0] payload,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [6:0]  entry_count
);
  import skt_pkg::*;

  localparam logic [6:0] DEPTH_7 = 7'(TABLE_DEPTH);

  // A refused insert reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == DEPTH_7)
    else $error("full status with count below depth");

  // An empty refusal reports no records
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == 7'd0)
    else $error("empty status with nonzero count");

  // A new item is never taken while a result is stuck in the output register
  a_no_take_when_stuck: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result held");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

  // A stalled request keeps its fields
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(action) && $stable(record_key) &&
                             $stable(new_key) && $stable(payload))
    else $error("stalled request changed");

endmodule

bind sorted_key_table_top skt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_skt_checker (.*);

`default_nettype wire

// ===== dv/sorted_key_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sorted key table: mirrors the table contents and checks every result.
module sorted_key_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         action,
  input  wire logic signed [31:0] record_key,
  input  wire logic signed [31:0] new_key,
  input  wire logic [31:0]        payload,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         status,
  input  wire logic [6:0]         entry_count,
  output int                      errors,
  output int                      outstanding
);
  import skt_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
  } table_reply_t;

  // Mirror of the table: slots 0 .. mirror_count-1 are valid and sorted
  logic signed [31:0] mirror_key [TABLE_DEPTH];
  logic [31:0]        mirror_pay [TABLE_DEPTH];
  int unsigned        mirror_count;
  table_reply_t       reply_q [$];

  // Put a record behind every record with a key that is not greater
  function automatic void insert_sorted(input logic signed [31:0] key,
                                        input logic [31:0] pay);
    int unsigned pos;
    pos = mirror_count;
    while (pos > 0 && mirror_key[pos-1] > key) begin
      mirror_key[pos] = mirror_key[pos-1];
      mirror_pay[pos] = mirror_pay[pos-1];
      pos--;
    end
    mirror_key[pos] = key;
    mirror_pay[pos] = pay;
    mirror_count++;
  endfunction

  // Apply one request to the mirror and return the reply it should give
  function automatic table_reply_t apply_request(input logic [1:0] act,
                                                 input logic signed [31:0] rkey,
                                                 input logic signed [31:0] nkey,
                                                 input logic [31:0] pay);
    table_reply_t reply;
    int unsigned  pos;
    int unsigned  j;
    logic [31:0]  kept;
    reply.status = ST_DONE;
    case (act)
      ACT_INSERT: begin
        if (mirror_count >= TABLE_DEPTH) reply.status = ST_FULL;
        else insert_sorted(rkey, pay);
      end
      ACT_DELETE, ACT_REKEY: begin
        if (mirror_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          // first slot holding the key
          pos = 0;
          while (pos < mirror_count && mirror_key[pos] != rkey) pos++;
          if (pos >= mirror_count) begin
            reply.status = ST_MISSING;
          end else begin
            kept = mirror_pay[pos];
            for (j = pos; j + 1 < mirror_count; j++) begin
              mirror_key[j] = mirror_key[j+1];
              mirror_pay[j] = mirror_pay[j+1];
            end
            mirror_count--;
            if (act == ACT_REKEY) insert_sorted(nkey, kept);
          end
        end
      end
      default: ;  // unused code: no change
    endcase
    reply.entry_count = mirror_count[6:0];
    return reply;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%0t checker: %s", $realtime, msg);
  endtask

  // Predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin : watch
    table_reply_t want;
    if (rst) begin
      mirror_count = 0;
      reply_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall)
        reply_q.push_back(apply_request(action, record_key, new_key, payload));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: status %0d entry_count %0d",
                                 status, entry_count));
        end else begin
          want = reply_q.pop_front();
          if (want.status !== status || want.entry_count !== entry_count)
            note_failure($sformatf("status exp %0d got %0d, entry_count exp %0d got %0d",
                                   want.status, status, want.entry_count, entry_count));
        end
      end
    end
    outstanding = reply_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the sorted key table: clock, reset, request traffic and verdict.
module tb;
  import skt_pkg::*;

  localparam int DEPTH        = 64;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam longint TIME_LIMIT_NS = 5_000_000;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD
  } idle_mode_t;

  localparam idle_mode_t PHASE_MODE [PHASES] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
    IDLE_HOLD, IDLE_BOTH, IDLE_RECV, IDLE_SEND
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         action;
  logic signed [31:0] record_key;
  logic signed [31:0] new_key;
  logic [31:0]        payload;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [6:0]         entry_count;
  int                 errors;
  int                 outstanding;

  idle_mode_t         idle_mode;
  // keys believed to be in the table, used to aim deletes and key changes
  logic signed [31:0] live_keys [$];

  sorted_key_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .record_key  (record_key),
    .new_key     (new_key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
  );

  sorted_key_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .record_key  (record_key),
    .new_key     (new_key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("tb: FAIL");
    $finish;
  end

  // Result side: random stalls per mode, one long hold-off in hold mode
  initial begin : result_side
    int hold_len;
    hold_len = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_mode == IDLE_HOLD && hold_len < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_len++;
      end else begin
        case (idle_mode)
          IDLE_RECV: out_stall <= ($urandom_range(99) < 56);
          IDLE_BOTH: out_stall <= ($urandom_range(99) < 36);
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Often small keys so duplicates and hits are common, some extremes, half full range
  function automatic logic signed [31:0] pick_key();
    int sel;
    int small_key;
    sel = $urandom_range(99);
    small_key = $urandom_range(16);
    if (sel < 40) return small_key - 8;
    if (sel < 50) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Offer one item, with random gaps before it, and wait until it is taken
  task automatic send_item(input logic [1:0] act, input logic signed [31:0] rkey,
                           input logic signed [31:0] nkey, input logic [31:0] pay);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 56 : (idle_mode == IDLE_BOTH) ? 36 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    record_key <= rkey;
    new_key    <= nkey;
    payload    <= pay;
    do @(posedge clk); while (in_stall);
  endtask

  // One random request, biased toward filling or toward draining the table
  task automatic random_request(input bit fill);
    int                 sel;
    int                 idx;
    logic [1:0]         act;
    logic signed [31:0] rkey;
    logic signed [31:0] nkey;
    sel = $urandom_range(99);
    if (fill)
      act = (sel < 75) ? ACT_INSERT : (sel < 90) ? ACT_DELETE :
            (sel < 98) ? ACT_REKEY : ACT_UNUSED;
    else
      act = (sel < 12) ? ACT_INSERT : (sel < 77) ? ACT_DELETE :
            (sel < 97) ? ACT_REKEY : ACT_UNUSED;
    rkey = pick_key();
    nkey = pick_key();
    if (act == ACT_INSERT) begin
      live_keys.push_back(rkey);
      if (live_keys.size() > DEPTH) void'(live_keys.pop_front());
    end else if ((act == ACT_DELETE || act == ACT_REKEY) && live_keys.size() > 0 &&
                 $urandom_range(99) < 80) begin
      idx = $urandom_range(live_keys.size() - 1);
      rkey = live_keys[idx];
      if (act == ACT_DELETE) live_keys.delete(idx);
      else live_keys[idx] = nkey;
    end
    send_item(act, rkey, nkey, $urandom);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_INSERT;
    record_key = '0;
    new_key    = '0;
    payload    = '0;
    idle_mode  = IDLE_NONE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, duplicates, missing keys, key changes
    send_item(ACT_DELETE, 0, 0, 32'h0);
    send_item(ACT_REKEY, 0, 5, 32'h0);
    send_item(ACT_UNUSED, 0, 0, 32'h0);
    send_item(ACT_INSERT, KEY_MIN, 0, 32'h0000_0000);
    send_item(ACT_INSERT, KEY_MAX, 0, 32'hffff_ffff);
    send_item(ACT_INSERT, 0, 0, 32'h0000_0001);
    send_item(ACT_INSERT, 0, 0, 32'h0000_0002);
    send_item(ACT_INSERT, -1, 0, 32'h0000_0003);
    send_item(ACT_DELETE, 5, 0, 32'h0);
    send_item(ACT_REKEY, 7, 1, 32'h0);
    send_item(ACT_REKEY, 0, 0, 32'h0);          // same key: moves behind the other 0
    send_item(ACT_DELETE, 0, 0, 32'h0);
    send_item(ACT_REKEY, KEY_MAX, KEY_MIN, 32'h0);
    send_item(ACT_REKEY, KEY_MIN, KEY_MAX, 32'h0);
    send_item(ACT_UNUSED, KEY_MAX, KEY_MIN, 32'hffff_ffff);
    send_item(ACT_INSERT, 32'sh5555_5555, 0, 32'haaaa_aaaa);
    send_item(ACT_INSERT, 32'shaaaa_aaaa, 0, 32'h5555_5555);
    send_item(ACT_DELETE, KEY_MIN, 0, 32'h0);
    send_item(ACT_DELETE, KEY_MAX, 0, 32'h0);
    send_item(ACT_DELETE, 0, 0, 32'h0);
    send_item(ACT_DELETE, -1, 0, 32'h0);
    send_item(ACT_DELETE, 32'sh5555_5555, 0, 32'h0);
    send_item(ACT_DELETE, 32'shaaaa_aaaa, 0, 32'h0);
    send_item(ACT_DELETE, 0, 0, 32'h0);         // empty again

    // Random: alternate filling to full and draining to empty across idle modes
    for (int p = 0; p < PHASES; p++) begin
      idle_mode <= PHASE_MODE[p];
      repeat (PHASE_ITEMS) random_request(p % 2 == 0);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_top.sv
hw/rtl/skt_checker.sv
dv/sorted_key_table_checker.sv
dv/tb.sv
